### src/cnp_pkg.sv
// Shared types and constants for the cylinder normal and projection block.
package cnp_pkg;

    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 33;

    localparam logic [47:0]        INV_MAX   = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0]        INV_RESET = 48'h0001_0000_0000;
    localparam logic signed [31:0] AXIS_ONE  = 32'sh4000_0000;
    localparam logic signed [34:0] DOT_MAX   = 35'sh1_FFFF_FFFF;
    localparam logic signed [31:0] I32_MAX   = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] I32_MIN   = 32'sh8000_0000;

    typedef enum logic [2:0] {
        REG_CENTER_X,
        REG_CENTER_Y,
        REG_CENTER_Z,
        REG_AXIS_X,
        REG_AXIS_Y,
        REG_AXIS_Z,
        REG_RADIUS,
        REG_TINY
    } reg_idx_t;

    typedef enum logic {
        RECIP_IDLE,
        RECIP_RUN
    } recip_state_t;

    typedef logic [31:0] word_t;

    typedef struct packed {
        word_t [2:0] center;
        word_t [2:0] axis;
        word_t       radius;
        logic [47:0] inv;
    } cfg_t;

    // point, perpendicular offset and fast normal of one item
    typedef struct packed {
        word_t [2:0] p;
        word_t [2:0] n;
        word_t [2:0] f;
    } side_t;

    typedef struct packed {
        side_t side;
        logic  nok;
        logic  sok;
    } bside_t;

endpackage

### src/cnp_cfg.sv
// Configuration registers, register read port and reciprocal radius unit.
module cnp_cfg import cnp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg,
    output logic        busy
);

    word_t        center_reg [3];
    word_t        axis_reg [3];
    word_t        radius_reg;
    logic [15:0]  tiny_reg;
    logic [47:0]  inv_reg, inv_next;
    recip_state_t state_reg, state_next;
    logic         start_reg, start_next;
    logic [5:0]   cnt_reg, cnt_next;
    logic [31:0]  rem_reg, rem_next;
    logic [48:0]  q_reg, q_next;
    logic [48:0]  num_reg, num_next;

    logic         wr;
    reg_idx_t     idx;
    logic [31:0]  mag;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[4:2]);
    assign mag    = radius_reg[31] ? 32'(-radius_reg) : radius_reg;
    assign busy   = start_reg || (state_reg != RECIP_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_reg[0] <= '0;
            center_reg[1] <= '0;
            center_reg[2] <= '0;
            axis_reg[0]   <= '0;
            axis_reg[1]   <= '0;
            axis_reg[2]   <= AXIS_ONE;
            radius_reg    <= 32'h0001_0000;
            tiny_reg      <= 16'h0001;
        end else if (wr) begin
            case (idx)
                REG_CENTER_X: center_reg[0] <= pwdata;
                REG_CENTER_Y: center_reg[1] <= pwdata;
                REG_CENTER_Z: center_reg[2] <= pwdata;
                REG_AXIS_X:   axis_reg[0]   <= pwdata;
                REG_AXIS_Y:   axis_reg[1]   <= pwdata;
                REG_AXIS_Z:   axis_reg[2]   <= pwdata;
                REG_RADIUS:   radius_reg    <= pwdata;
                REG_TINY:     tiny_reg      <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_CENTER_X: prdata = center_reg[0];
            REG_CENTER_Y: prdata = center_reg[1];
            REG_CENTER_Z: prdata = center_reg[2];
            REG_AXIS_X:   prdata = axis_reg[0];
            REG_AXIS_Y:   prdata = axis_reg[1];
            REG_AXIS_Z:   prdata = axis_reg[2];
            REG_RADIUS:   prdata = radius_reg;
            REG_TINY:     prdata = {16'h0000, tiny_reg};
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= RECIP_IDLE;
            start_reg <= 1'b0;
            inv_reg   <= INV_RESET;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            start_reg <= start_next;
            inv_reg   <= inv_next;
            cnt_reg   <= cnt_next;
        end
        rem_reg <= rem_next;
        q_reg   <= q_next;
        num_reg <= num_next;
    end

    // restoring division of 2^48 + |r|/2 by |r|, one quotient bit a cycle
    always_comb begin
        logic [32:0] t;
        logic        ge;
        logic [48:0] qf;
        logic [47:0] qs;
        state_next = state_reg;
        inv_next   = inv_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        q_next     = q_reg;
        num_next   = num_reg;
        t          = {rem_reg, num_reg[48]};
        ge         = (t >= {1'b0, mag});
        qf         = {q_reg[47:0], ge};
        qs         = (qf > {1'b0, INV_MAX}) ? INV_MAX : qf[47:0];
        start_next = (state_reg == RECIP_IDLE) ? 1'b0 : start_reg;
        case (state_reg)
            RECIP_IDLE: begin
                if (start_reg) begin
                    if (mag == '0 || mag <= {16'h0000, tiny_reg}) begin
                        inv_next = INV_MAX;
                    end else begin
                        num_next   = {1'b1, 17'h00000, mag[31:1]};
                        rem_next   = '0;
                        q_next     = '0;
                        cnt_next   = 6'd48;
                        state_next = RECIP_RUN;
                    end
                end
            end
            RECIP_RUN: begin
                rem_next = ge ? 32'(t - {1'b0, mag}) : t[31:0];
                q_next   = qf;
                num_next = {num_reg[47:0], 1'b0};
                if (cnt_reg == '0) begin
                    inv_next   = radius_reg[31] ? 48'(-qs) : qs;
                    state_next = RECIP_IDLE;
                end else begin
                    cnt_next = cnt_reg - 6'd1;
                end
            end
            default: state_next = RECIP_IDLE;
        endcase
        if (wr && (idx == REG_RADIUS || idx == REG_TINY)) begin
            start_next = 1'b1;
        end
    end

    assign cfg.center = {center_reg[2], center_reg[1], center_reg[0]};
    assign cfg.axis   = {axis_reg[2], axis_reg[1], axis_reg[0]};
    assign cfg.radius = radius_reg;
    assign cfg.inv    = inv_reg;

endmodule

### src/cnp_front.sv
// Front pipeline: axial projection, perpendicular offset, squared length, fast normal.
module cnp_front import cnp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        en,
    input  logic        in_valid,
    input  logic [95:0] in_data,
    input  cfg_t        cfg,
    output logic        out_valid,
    output side_t       out_side,
    output logic [63:0] out_sq
);

    logic [7:0]         vld_reg;
    logic signed [31:0] p_reg [8][3];
    logic signed [32:0] d1_reg [3], d1_next [3];
    logic signed [32:0] d2_reg [3], d3_reg [3], d4_reg [3], d5_reg [3];
    logic signed [31:0] a1_reg [3], a1_next [3];
    logic signed [31:0] a2_reg [3], a3_reg [3], a4_reg [3];
    logic signed [64:0] t2_reg [3], t2_next [3];
    logic signed [36:0] hisum3_reg, hisum3_next;
    logic [31:0]        losum3_reg, losum3_next;
    logic signed [34:0] dot4_reg, dot4_next;
    logic signed [66:0] m5_reg [3], m5_next [3];
    logic signed [31:0] n6_reg [3], n6_next [3];
    logic signed [31:0] n7_reg [3], n8_reg [3];
    logic [63:0]        sq7_reg [3], sq7_next [3];
    logic [46:0]        pa7_reg [3], pa7_next [3];
    logic [63:0]        pb7_reg [3], pb7_next [3];
    logic               neg7_reg [3], neg7_next [3];
    logic [63:0]        sq8_reg, sq8_next;
    logic signed [31:0] f8_reg [3], f8_next [3];

    always_comb begin
        logic signed [31:0] ax;
        logic signed [34:0] hi;
        logic signed [37:0] dsum;
        logic [31:0]        lr;
        logic signed [66:0] mr;
        logic signed [36:0] proj;
        logic signed [37:0] diff;
        logic signed [63:0] sqs;
        logic [31:0]        an;
        logic [47:0]        binv;
        logic [64:0]        fr;
        logic [47:0]        fmag;
        hisum3_next = '0;
        losum3_next = '0;
        sq8_next    = '0;
        binv        = cfg.inv[47] ? 48'(-cfg.inv) : cfg.inv;
        for (int i = 0; i < 3; i++) begin
            d1_next[i] = $signed({in_data[32*i+31], in_data[32*i +: 32]})
                       - $signed({cfg.center[i][31], cfg.center[i]});
            ax = $signed(cfg.axis[i]);
            a1_next[i] = (ax > AXIS_ONE) ? AXIS_ONE : ((ax < -AXIS_ONE) ? -AXIS_ONE : ax);
            t2_next[i] = d1_reg[i] * a1_reg[i];
            hi = $signed(t2_reg[i][64:30]);
            hisum3_next = hisum3_next + hi;
            losum3_next = losum3_next + {2'b00, t2_reg[i][29:0]};
            m5_next[i] = a4_reg[i] * dot4_reg;
            mr   = m5_reg[i] + 67'sd536870912;
            proj = $signed(mr[66:30]);
            diff = d5_reg[i] - proj;
            n6_next[i] = (diff > I32_MAX) ? I32_MAX : ((diff < I32_MIN) ? I32_MIN : diff[31:0]);
            sqs = n6_reg[i] * n6_reg[i];
            sq7_next[i] = $unsigned(sqs);
            an = n6_reg[i][31] ? 32'(-n6_reg[i]) : $unsigned(n6_reg[i]);
            pa7_next[i]  = an * binv[46:32];
            pb7_next[i]  = an * binv[31:0];
            neg7_next[i] = (n6_reg[i][31] == cfg.inv[47]);
            sq8_next = sq8_next + sq7_reg[i];
            fr   = {1'b0, pb7_reg[i]} + 65'h0_8000_0000;
            fmag = {1'b0, pa7_reg[i]} + {15'h0000, fr[64:32]};
            if (neg7_reg[i]) begin
                f8_next[i] = (fmag > 48'h8000_0000) ? I32_MIN : $signed(32'(48'h0 - fmag));
            end else begin
                f8_next[i] = (fmag > 48'h7FFF_FFFF) ? I32_MAX : $signed(fmag[31:0]);
            end
        end
        // low parts carry a rounding term into the dot product
        lr   = losum3_reg + 32'h2000_0000;
        dsum = hisum3_reg + $signed({1'b0, lr[31:30]});
        dot4_next = (dsum > DOT_MAX) ? DOT_MAX : ((dsum < -DOT_MAX) ? -DOT_MAX : dsum[34:0]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[6:0], in_valid};
        end
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                p_reg[0][i] <= $signed(in_data[32*i +: 32]);
                for (int s = 1; s < 8; s++) begin
                    p_reg[s][i] <= p_reg[s-1][i];
                end
                d1_reg[i]   <= d1_next[i];
                d2_reg[i]   <= d1_reg[i];
                d3_reg[i]   <= d2_reg[i];
                d4_reg[i]   <= d3_reg[i];
                d5_reg[i]   <= d4_reg[i];
                a1_reg[i]   <= a1_next[i];
                a2_reg[i]   <= a1_reg[i];
                a3_reg[i]   <= a2_reg[i];
                a4_reg[i]   <= a3_reg[i];
                t2_reg[i]   <= t2_next[i];
                m5_reg[i]   <= m5_next[i];
                n6_reg[i]   <= n6_next[i];
                n7_reg[i]   <= n6_reg[i];
                n8_reg[i]   <= n7_reg[i];
                sq7_reg[i]  <= sq7_next[i];
                pa7_reg[i]  <= pa7_next[i];
                pb7_reg[i]  <= pb7_next[i];
                neg7_reg[i] <= neg7_next[i];
                f8_reg[i]   <= f8_next[i];
            end
            hisum3_reg <= hisum3_next;
            losum3_reg <= losum3_next;
            dot4_reg   <= dot4_next;
            sq8_reg    <= sq8_next;
        end
    end

    assign out_valid  = vld_reg[7];
    assign out_sq     = sq8_reg;
    assign out_side.p = {p_reg[7][2], p_reg[7][1], p_reg[7][0]};
    assign out_side.n = {n8_reg[2], n8_reg[1], n8_reg[0]};
    assign out_side.f = {f8_reg[2], f8_reg[1], f8_reg[0]};

endmodule

### src/cnp_sqrt.sv
// Pipelined integer square root, one result bit per stage.
module cnp_sqrt import cnp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        en,
    input  logic        in_valid,
    input  side_t       in_side,
    input  logic [63:0] in_sq,
    output logic        out_valid,
    output side_t       out_side,
    output logic [31:0] out_rp
);

    logic [SQRT_STEPS-1:0] vld_reg;
    side_t                 side_reg [SQRT_STEPS];
    logic [33:0]           rem_reg [SQRT_STEPS], rem_next [SQRT_STEPS];
    logic [31:0]           root_reg [SQRT_STEPS], root_next [SQRT_STEPS];
    logic [63:0]           v_reg [SQRT_STEPS], v_next [SQRT_STEPS];

    always_comb begin
        logic [33:0] prem;
        logic [31:0] proot;
        logic [63:0] pv;
        logic [35:0] t;
        logic [35:0] trial;
        logic        ge;
        for (int k = 0; k < SQRT_STEPS; k++) begin
            prem  = (k == 0) ? 34'h0 : rem_reg[(k == 0) ? 0 : k-1];
            proot = (k == 0) ? 32'h0 : root_reg[(k == 0) ? 0 : k-1];
            pv    = (k == 0) ? in_sq : v_reg[(k == 0) ? 0 : k-1];
            t     = {prem, pv[63:62]};
            trial = {2'b00, proot, 2'b01};
            ge    = (t >= trial);
            rem_next[k]  = ge ? 34'(t - trial) : t[33:0];
            root_next[k] = {proot[30:0], ge};
            v_next[k]    = {pv[61:0], 2'b00};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[SQRT_STEPS-2:0], in_valid};
        end
        if (en) begin
            side_reg[0] <= in_side;
            for (int k = 1; k < SQRT_STEPS; k++) begin
                side_reg[k] <= side_reg[k-1];
            end
            for (int k = 0; k < SQRT_STEPS; k++) begin
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
                v_reg[k]    <= v_next[k];
            end
        end
    end

    assign out_valid = vld_reg[SQRT_STEPS-1];
    assign out_side  = side_reg[SQRT_STEPS-1];
    assign out_rp    = root_reg[SQRT_STEPS-1];

endmodule

### src/cnp_div.sv
// Pipelined restoring divider, one quotient bit per stage; quotient must fit 33 bits.
module cnp_div import cnp_pkg::*; (
    input  logic        aclk,
    input  logic        en,
    input  logic [63:0] num,
    input  logic [31:0] den,
    output logic [32:0] quot
);

    logic [31:0] rem_reg [DIV_STEPS], rem_next [DIV_STEPS];
    logic [32:0] low_reg [DIV_STEPS], low_next [DIV_STEPS];
    logic [32:0] q_reg [DIV_STEPS], q_next [DIV_STEPS];
    logic [31:0] den_reg [DIV_STEPS];

    always_comb begin
        logic [31:0] prem;
        logic [32:0] plow;
        logic [32:0] pq;
        logic [31:0] pden;
        logic [32:0] t;
        logic        ge;
        for (int k = 0; k < DIV_STEPS; k++) begin
            prem = (k == 0) ? {1'b0, num[63:33]} : rem_reg[(k == 0) ? 0 : k-1];
            plow = (k == 0) ? num[32:0] : low_reg[(k == 0) ? 0 : k-1];
            pq   = (k == 0) ? 33'h0 : q_reg[(k == 0) ? 0 : k-1];
            pden = (k == 0) ? den : den_reg[(k == 0) ? 0 : k-1];
            t    = {prem, plow[32]};
            ge   = (t >= {1'b0, pden});
            rem_next[k] = ge ? 32'(t - {1'b0, pden}) : t[31:0];
            low_next[k] = {plow[31:0], 1'b0};
            q_next[k]   = {pq[31:0], ge};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            den_reg[0] <= den;
            for (int k = 1; k < DIV_STEPS; k++) begin
                den_reg[k] <= den_reg[k-1];
            end
            for (int k = 0; k < DIV_STEPS; k++) begin
                rem_reg[k] <= rem_next[k];
                low_reg[k] <= low_next[k];
                q_reg[k]   <= q_next[k];
            end
        end
    end

    assign quot = q_reg[DIV_STEPS-1];

endmodule

### src/cnp_back.sv
// Back pipeline: validity checks, exact normal and surface point divisions, output register.
module cnp_back import cnp_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         en,
    input  logic         in_valid,
    input  side_t        in_side,
    input  logic [31:0]  in_rp,
    input  cfg_t         cfg,
    output logic         out_valid,
    output logic [287:0] out_data,
    output logic [1:0]   out_user
);

    logic                 vld1_reg, vld2_reg;
    logic [DIV_STEPS-1:0] dvld_reg;
    bside_t               b1_reg, b1_next, b2_reg;
    bside_t               dly_reg [DIV_STEPS];
    logic [31:0]          rp1_reg, rp2_reg;
    logic [63:0]          prod1_reg [3], prod1_next [3];
    logic [63:0]          nn1_reg [3], nn1_next [3];
    logic [63:0]          nn2_reg [3], ns2_reg [3], ns2_next [3];
    logic [32:0]          qn [3], qs [3];
    logic                 out_vld_reg;
    logic [287:0]         data_reg, data_next;
    logic [1:0]           user_reg, user_next;
    logic [31:0]          rm;

    assign rm = cfg.radius[31] ? 32'(-cfg.radius) : cfg.radius;

    always_comb begin
        logic signed [33:0] diff;
        logic [33:0]        adiff;
        logic [31:0]        an;
        bside_t             last;
        logic               rpos;
        logic signed [33:0] vn, nr, vs;
        logic signed [35:0] ssum;
        word_t              sv;
        diff  = $signed({2'b00, in_rp}) - $signed({2'b00, rm});
        adiff = diff[33] ? 34'(-diff) : $unsigned(diff);
        b1_next.side = in_side;
        b1_next.sok  = (in_rp != '0);
        b1_next.nok  = (in_rp != '0) && ({adiff, 1'b0} <= {3'b000, rm});
        for (int i = 0; i < 3; i++) begin
            an = in_side.n[i][31] ? 32'(-in_side.n[i]) : in_side.n[i];
            prod1_next[i] = an * rm;
            nn1_next[i]   = {2'b00, an, 30'h0} + {33'h0, in_rp[31:1]};
            ns2_next[i]   = prod1_reg[i] + {33'h0, rp1_reg[31:1]};
        end

        last = dly_reg[DIV_STEPS-1];
        rpos = !cfg.radius[31] && (cfg.radius != '0);
        data_next = '0;
        for (int i = 0; i < 3; i++) begin
            vn = last.side.n[i][31] ? -$signed({1'b0, qn[i]}) : $signed({1'b0, qn[i]});
            nr = rpos ? vn : -vn;
            data_next[32*i +: 32] = last.nok ? nr[31:0] : 32'h0;
            vs = last.side.n[i][31] ? -$signed({1'b0, qs[i]}) : $signed({1'b0, qs[i]});
            ssum = $signed(last.side.p[i]) - $signed(last.side.n[i]) + vs;
            sv = (ssum > I32_MAX) ? I32_MAX : ((ssum < I32_MIN) ? I32_MIN : ssum[31:0]);
            data_next[96 + 32*i +: 32]  = last.sok ? sv : 32'h0;
            data_next[192 + 32*i +: 32] = last.side.f[i];
        end
        user_next = {last.sok, last.nok};
    end

    for (genvar g = 0; g < 3; g++) begin : g_lane
        cnp_div u_div_norm (
            .aclk (aclk),
            .en   (en),
            .num  (nn2_reg[g]),
            .den  (rp2_reg),
            .quot (qn[g])
        );
        cnp_div u_div_surf (
            .aclk (aclk),
            .en   (en),
            .num  (ns2_reg[g]),
            .den  (rp2_reg),
            .quot (qs[g])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg    <= 1'b0;
            vld2_reg    <= 1'b0;
            dvld_reg    <= '0;
            out_vld_reg <= 1'b0;
        end else if (en) begin
            vld1_reg    <= in_valid;
            vld2_reg    <= vld1_reg;
            dvld_reg    <= {dvld_reg[DIV_STEPS-2:0], vld2_reg};
            out_vld_reg <= dvld_reg[DIV_STEPS-1];
        end
        if (en) begin
            b1_reg  <= b1_next;
            b2_reg  <= b1_reg;
            rp1_reg <= in_rp;
            rp2_reg <= rp1_reg;
            for (int i = 0; i < 3; i++) begin
                prod1_reg[i] <= prod1_next[i];
                nn1_reg[i]   <= nn1_next[i];
                nn2_reg[i]   <= nn1_reg[i];
                ns2_reg[i]   <= ns2_next[i];
            end
            dly_reg[0] <= b2_reg;
            for (int k = 1; k < DIV_STEPS; k++) begin
                dly_reg[k] <= dly_reg[k-1];
            end
            data_reg <= data_next;
            user_reg <= user_next;
        end
    end

    assign out_valid = out_vld_reg;
    assign out_data  = data_reg;
    assign out_user  = user_reg;

endmodule

### src/cylinder_normal_and_projection.sv
// Cylinder normal and projection: one point in, one result item out every cycle
// while the output is taken and no reciprocal rebuild runs (8 front stages, a
// 32-stage square root, and 36 stages around the 33-stage dividers for the exact
// normal and surface point). The whole pipeline advances whenever the output
// register is empty or being taken. After a write to radius or tiny_radius the
// reciprocal radius is rebuilt, bit-serially unless |radius| <= tiny_radius;
// s_tready stays low meanwhile, and longer when a second such write lands.
module cylinder_normal_and_projection import cnp_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,   // px, py, pz
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [287:0] m_tdata,   // nx, ny, nz, sx, sy, sz, fx, fy, fz
    output logic [1:0]   m_tuser,   // normal_ok, surface_ok
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    cfg_t        cfg;
    logic        busy;
    logic        en;
    logic        in_valid;
    logic        fr_valid;
    side_t       fr_side;
    logic [63:0] fr_sq;
    logic        sq_valid;
    side_t       sq_side;
    logic [31:0] sq_rp;

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en && !busy;
    assign in_valid = s_tvalid && s_tready;

    cnp_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg),
        .busy    (busy)
    );

    cnp_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (in_valid),
        .in_data   (s_tdata),
        .cfg       (cfg),
        .out_valid (fr_valid),
        .out_side  (fr_side),
        .out_sq    (fr_sq)
    );

    cnp_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (fr_valid),
        .in_side   (fr_side),
        .in_sq     (fr_sq),
        .out_valid (sq_valid),
        .out_side  (sq_side),
        .out_rp    (sq_rp)
    );

    cnp_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (sq_valid),
        .in_side   (sq_side),
        .in_rp     (sq_rp),
        .cfg       (cfg),
        .out_valid (m_tvalid),
        .out_data  (m_tdata),
        .out_user  (m_tuser)
    );

endmodule
